@@ rtl/sha384_pkg.sv @@
// Shared types, constants and round functions of the SHA-384 engine.
`default_nettype none
package sha384_pkg;

    localparam int unsigned WORD_BITS   = 64;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned WIDX_BITS   = 4;
    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned RND_BITS    = 7;
    localparam int unsigned FILL_BITS   = 7;
    localparam int unsigned COUNT_BITS  = 61;
    localparam int unsigned DIGEST_WORDS = 6;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        CMD_ABSORB  = 2'd0,
        CMD_FINISH  = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_PRIME,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    localparam t_word INIT_H [8] = '{
        64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
        64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
        64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
    };

    localparam t_word ROUND_K [ROUNDS] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WORD_BITS - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

endpackage
`default_nettype wire

@@ rtl/sha384_in_if.sv @@
// Input channel: command beats with valid and ready.
`default_nettype none
interface sha384_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/sha384_out_if.sv @@
// Output channel: digest word beats with valid and ready.
`default_nettype none
interface sha384_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/sha384_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module sha384_ram #(
    parameter int unsigned P_WIDTH = 64,
    parameter int unsigned P_DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  wire logic [P_WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic      [P_WIDTH-1:0]         o_rdata
);
    logic [P_WIDTH-1:0] r_mem [P_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/sha384_hash_engine.sv @@
// SHA-384 engine: absorb bytes one per beat, compress 128-byte blocks, emit the digest.
// Absorb: each accepted beat takes one byte; the beat that fills a block starts the load,
// prime, 80 rounds and hash add on the single round unit, and no byte is taken until done.
// Finish: pad words from fill / 8 up to word 15 are written, then compressed the same way;
// a length-only pad block follows when under 17 bytes of room remain; then six output beats.
// Reset (synchronous, active low) loads the initial hash and clears fill, byte and word counts.
`default_nettype none
module sha384_hash_engine (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    sha384_in_if.sink     i_in,
    sha384_out_if.source  o_out
);
    import sha384_pkg::*;

    t_state                    r_state, n_state;
    t_word                     r_h   [8];
    t_word                     r_v   [8];
    t_word                     r_win [BLOCK_WORDS-1];
    t_word                     r_w;
    t_word                     r_pack;
    logic [FILL_BITS-1:0]      r_fill;
    logic [COUNT_BITS-1:0]     r_bytes;
    logic [RND_BITS-1:0]       r_rnd;
    logic [WIDX_BITS-1:0]      r_widx;
    logic                      r_first;
    logic                      r_lenblk;
    logic                      r_fin;
    logic                      r_final;
    logic [2:0]                r_oidx;

    logic                      ram_we;
    logic [WIDX_BITS-1:0]      ram_waddr;
    t_word                     ram_wdata;
    logic [WIDX_BITS-1:0]      ram_raddr;
    t_word                     ram_rdata;

    logic                      in_acc;
    logic                      out_acc;
    logic [2*WORD_BITS-1:0]    pad_wide;
    t_word                     pad_word;
    t_word                     sched_w;
    t_word                     t1;
    t_word                     t2;
    logic [RND_BITS-1:0]       rnd_ahead;

    sha384_ram #(
        .P_WIDTH (WORD_BITS),
        .P_DEPTH (BLOCK_WORDS)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    // Held bytes move to the top of the word, followed by the 0x80 marker and zeros.
    assign pad_wide = {r_pack, 8'h80, 56'd0} << {(4'd8 - {1'b0, r_fill[2:0]}), 3'd0};
    assign pad_word = pad_wide[2*WORD_BITS-1:WORD_BITS];

    assign sched_w = small_sigma1(r_win[0]) + r_win[5] + small_sigma0(r_win[13]) + r_win[14];
    assign t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + ROUND_K[r_rnd] + r_w;
    assign t2 = big_sigma0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign rnd_ahead = r_rnd + RND_BITS'(2);

    assign o_out.digest_word = r_h[r_oidx];
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = (r_oidx == 3'(DIGEST_WORDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_fill[FILL_BITS-1:3];
        ram_wdata   = {r_pack[WORD_BITS-9:0], i_in.data_byte};
        ram_raddr   = '0;
        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    unique case (t_cmd'(i_in.command))
                        CMD_ABSORB: begin
                            ram_we = (r_fill[2:0] == 3'd7);
                            if (r_fill == FILL_BITS'(127)) begin
                                n_state = ST_LOAD;
                            end
                        end
                        CMD_FINISH:  n_state = ST_PAD;
                        CMD_RESTART: n_state = ST_IDLE;
                        CMD_UNUSED:  n_state = ST_IDLE;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PAD: begin
                ram_we    = 1'b1;
                ram_waddr = r_widx;
                if (r_first) begin
                    ram_wdata = pad_word;
                end else if (r_lenblk && r_widx == WIDX_BITS'(BLOCK_WORDS - 1)) begin
                    ram_wdata = {r_bytes, 3'd0};
                end else begin
                    ram_wdata = '0;
                end
                if (r_widx == WIDX_BITS'(BLOCK_WORDS - 1)) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                ram_raddr = '0;
                n_state   = ST_PRIME;
            end
            ST_PRIME: begin
                ram_raddr = WIDX_BITS'(1);
                n_state   = ST_ROUND;
            end
            ST_ROUND: begin
                ram_raddr = rnd_ahead[WIDX_BITS-1:0];
                if (r_rnd == RND_BITS'(ROUNDS - 1)) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (r_final) begin
                    n_state = ST_OUT;
                end else if (r_fin) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                o_out.valid = 1'b1;
                if (o_out.ready && r_oidx == 3'(DIGEST_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h     <= INIT_H;
            r_fill  <= '0;
            r_bytes <= '0;
            r_oidx  <= '0;
            r_fin   <= 1'b0;
            r_final <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        case (t_cmd'(i_in.command))
                            CMD_ABSORB: begin
                                r_pack  <= {r_pack[WORD_BITS-9:0], i_in.data_byte};
                                r_fill  <= r_fill + FILL_BITS'(1);
                                r_bytes <= r_bytes + COUNT_BITS'(1);
                                r_fin   <= 1'b0;
                                r_final <= 1'b0;
                            end
                            CMD_FINISH: begin
                                r_widx   <= r_fill[FILL_BITS-1:3];
                                r_first  <= 1'b1;
                                // The length fits only when the marker lands before word 14.
                                r_lenblk <= (r_fill[FILL_BITS-1:3] < WIDX_BITS'(14));
                                r_fin    <= 1'b1;
                            end
                            CMD_RESTART: begin
                                r_h     <= INIT_H;
                                r_fill  <= '0;
                                r_bytes <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_PAD: begin
                    r_first <= 1'b0;
                    r_widx  <= r_widx + WIDX_BITS'(1);
                    r_final <= r_lenblk;
                end
                ST_LOAD: begin
                    r_v <= r_h;
                end
                ST_PRIME: begin
                    r_w   <= ram_rdata;
                    r_rnd <= '0;
                end
                ST_ROUND: begin
                    r_win[0] <= r_w;
                    for (int j = 1; j < BLOCK_WORDS - 1; j++) begin
                        r_win[j] <= r_win[j-1];
                    end
                    // The next word comes from the buffer during the first fifteen rounds, and from the schedule after.
                    r_w <= (r_rnd < RND_BITS'(15)) ? ram_rdata : sched_w;
                    r_v[0] <= t1 + t2;
                    r_v[1] <= r_v[0];
                    r_v[2] <= r_v[1];
                    r_v[3] <= r_v[2];
                    r_v[4] <= r_v[3] + t1;
                    r_v[5] <= r_v[4];
                    r_v[6] <= r_v[5];
                    r_v[7] <= r_v[6];
                    r_rnd  <= r_rnd + RND_BITS'(1);
                end
                ST_ADD: begin
                    for (int j = 0; j < 8; j++) begin
                        r_h[j] <= r_h[j] + r_v[j];
                    end
                    // A second pad pass is an all-zero block carrying only the length.
                    r_widx   <= '0;
                    r_first  <= 1'b0;
                    r_lenblk <= 1'b1;
                    r_oidx   <= '0;
                end
                ST_OUT: begin
                    if (out_acc) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'(DIGEST_WORDS - 1)) begin
                            r_h     <= INIT_H;
                            r_fill  <= '0;
                            r_bytes <= '0;
                            r_fin   <= 1'b0;
                            r_final <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/sha384_chk.sv @@
// Port-level checker for the SHA-384 engine and its bind to the top level.
`default_nettype none
module sha384_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_word_index,
    input wire logic       i_last_word
);
    // No new command is taken while digest beats are pending.
    a_no_input_during_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input accepted while digest is being emitted");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last_word == (i_word_index == 3'd5)))
        else $error("last_word does not match the final word index");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last_word) |=>
            (i_out_valid && i_word_index == $past(i_word_index) + 3'd1))
        else $error("digest words not emitted in consecutive order");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_word_index)))
        else $error("stalled digest beat changed");
endmodule

bind sha384_hash_engine sha384_chk u_sha384_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_word_index (o_out.word_index),
    .i_last_word  (o_out.last_word)
);
`default_nettype wire
